@@ rtl/rbec_pkg.sv @@
// ----------------------------------------------------------------------------
// rbec_pkg
// shared types and constants of the rotating beacon edge capture unit
// ----------------------------------------------------------------------------
package rbec_pkg;

  localparam int MAX_BEACONS = 8;
  localparam int IDX_BITS    = 3;
  localparam int CNT_BITS    = 4;
  localparam int TIME_BITS   = 32;
  localparam int ERR_BITS    = 16;

  localparam logic [1:0] OP_TICK_BEAM  = 2'd0;
  localparam logic [1:0] OP_TICK_CLEAR = 2'd1;
  localparam logic [1:0] OP_FALL       = 2'd2;
  localparam logic [1:0] OP_RISE       = 2'd3;

  typedef struct packed {
    logic [1:0]           op;
    logic [TIME_BITS-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS-1:0] end_time;
    logic [CNT_BITS-1:0]  beacon_count;
    logic [IDX_BITS-1:0]  beacon_index;
    logic [TIME_BITS-1:0] fall_time;
    logic [TIME_BITS-1:0] rise_time;
    logic [ERR_BITS-1:0]  overflow_count;
    logic [ERR_BITS-1:0]  deferred_count;
    logic [ERR_BITS-1:0]  unexpected_count;
    logic                 last;
  } result_t;

endpackage

@@ rtl/rbec_front.sv @@
// ----------------------------------------------------------------------------
// rbec_front
// accepts input beats, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module rbec_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            func,
  input  logic                            laser_level,
  input  logic [rbec_pkg::TIME_BITS-1:0]  timestamp,
  output logic                            q_valid,
  output rbec_pkg::entry_t                q_entry,
  input  logic                            q_pop
);

  rbec_pkg::entry_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             push;
  logic [1:0]       op;

  always_comb begin
    unique case ({func, laser_level})
      2'b00:   op = rbec_pkg::OP_TICK_BEAM;
      2'b01:   op = rbec_pkg::OP_TICK_CLEAR;
      2'b10:   op = rbec_pkg::OP_FALL;
      default: op = rbec_pkg::OP_RISE;
    endcase
  end

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{op: op, stamp: timestamp};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/rbec_back.sv @@
// ----------------------------------------------------------------------------
// rbec_back
// capture mode machine, beacon slots and record emission through an output
// register
// ----------------------------------------------------------------------------
module rbec_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  rbec_pkg::entry_t   q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output rbec_pkg::result_t  result
);

  localparam logic [1:0] MODE_STD         = 2'd0;
  localparam logic [1:0] MODE_DISABLED    = 2'd1;
  localparam logic [1:0] MODE_LAST_ONE    = 2'd2;
  localparam logic [1:0] MODE_IGNORE_RISE = 2'd3;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  localparam logic [rbec_pkg::CNT_BITS-1:0] CNT_FULL =
    rbec_pkg::CNT_BITS'(rbec_pkg::MAX_BEACONS);
  localparam logic [rbec_pkg::ERR_BITS-1:0] ERR_MAX = '1;

  logic                               state;
  logic [1:0]                         mode;
  logic [1:0]                         pend_mode;
  logic [rbec_pkg::TIME_BITS-1:0]     pend_time;
  logic [rbec_pkg::TIME_BITS-1:0]     rot_start;
  logic [rbec_pkg::TIME_BITS-1:0]     rot_end;
  logic [rbec_pkg::CNT_BITS-1:0]      count;
  logic [rbec_pkg::IDX_BITS-1:0]      idx;
  logic [rbec_pkg::ERR_BITS-1:0]      err_ovf;
  logic [rbec_pkg::ERR_BITS-1:0]      err_def;
  logic [rbec_pkg::ERR_BITS-1:0]      err_unx;
  logic [rbec_pkg::MAX_BEACONS-1:0]   fall_vld;
  logic [rbec_pkg::TIME_BITS-1:0]     fall_slot [rbec_pkg::MAX_BEACONS];
  logic [rbec_pkg::TIME_BITS-1:0]     rise_slot [rbec_pkg::MAX_BEACONS];

  logic                               out_free;
  logic                               not_full;
  logic [rbec_pkg::IDX_BITS-1:0]      wr_idx;
  logic                               emit_last;
  logic [1:0]                         laser_mode;
  logic                               do_fall;
  logic                               do_rise;
  rbec_pkg::result_t                  res_next;

  function automatic logic [rbec_pkg::ERR_BITS-1:0] sat_inc(
    input logic [rbec_pkg::ERR_BITS-1:0] v);
    sat_inc = (v == ERR_MAX) ? v : v + 1'b1;
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign not_full = (count < CNT_FULL);
  assign wr_idx   = count[rbec_pkg::IDX_BITS-1:0];

  // mode seen by an edge once last-one mode has dropped to disabled
  assign laser_mode = (mode == MODE_LAST_ONE) ? MODE_DISABLED : mode;
  assign do_fall = q_pop && (q_entry.op == rbec_pkg::OP_FALL)
                   && (mode != MODE_DISABLED) && not_full;
  assign do_rise = q_pop && (q_entry.op == rbec_pkg::OP_RISE)
                   && (mode != MODE_DISABLED) && (laser_mode != MODE_IGNORE_RISE)
                   && not_full;

  assign emit_last = (count == '0)
                     || ({1'b0, idx} + rbec_pkg::CNT_BITS'(1) == count);

  always_comb begin
    res_next.start_time       = rot_start;
    res_next.end_time         = rot_end;
    res_next.beacon_count     = count;
    res_next.overflow_count   = err_ovf;
    res_next.deferred_count   = err_def;
    res_next.unexpected_count = err_unx;
    res_next.last             = emit_last;
    if (count == '0) begin
      res_next.beacon_index = '0;
      res_next.fall_time    = '0;
      res_next.rise_time    = '0;
    end else begin
      res_next.beacon_index = idx;
      res_next.fall_time    = fall_vld[idx] ? fall_slot[idx] : '0;
      res_next.rise_time    = rise_slot[idx];
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_fall) begin
      fall_slot[wr_idx] <= q_entry.stamp;
    end
    if (do_rise) begin
      rise_slot[wr_idx] <= q_entry.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && state == ST_EMIT) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= MODE_STD;
      pend_mode <= MODE_STD;
      pend_time <= '0;
      rot_start <= '0;
      rot_end   <= '0;
      count     <= '0;
      idx       <= '0;
      err_ovf   <= '0;
      err_def   <= '0;
      err_unx   <= '0;
      fall_vld  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            unique case (q_entry.op)
              rbec_pkg::OP_TICK_BEAM, rbec_pkg::OP_TICK_CLEAR: begin
                if (mode != MODE_DISABLED) begin
                  rot_end <= q_entry.stamp;
                end
                if (q_entry.op == rbec_pkg::OP_TICK_BEAM && mode == MODE_STD) begin
                  // beam still low: close one turn later
                  mode    <= MODE_LAST_ONE;
                  err_def <= sat_inc(err_def);
                end else begin
                  state     <= ST_EMIT;
                  idx       <= '0;
                  pend_time <= q_entry.stamp;
                  pend_mode <= (mode == MODE_DISABLED) ? MODE_IGNORE_RISE : MODE_STD;
                end
              end
              rbec_pkg::OP_FALL: begin
                if (mode != MODE_DISABLED) begin
                  mode <= laser_mode;
                  if (mode == MODE_LAST_ONE) begin
                    err_unx <= sat_inc(err_unx);
                  end
                  if (not_full) begin
                    fall_vld[wr_idx] <= 1'b1;
                  end
                end
              end
              default: begin
                if (mode != MODE_DISABLED) begin
                  if (laser_mode == MODE_IGNORE_RISE) begin
                    mode <= MODE_STD;
                  end else begin
                    mode <= laser_mode;
                    if (not_full) begin
                      count <= count + 1'b1;
                    end else begin
                      err_ovf <= sat_inc(err_ovf);
                    end
                  end
                end
              end
            endcase
          end
        end
        default: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (emit_last) begin
              // close the record and open the next rotation
              state     <= ST_IDLE;
              mode      <= pend_mode;
              rot_start <= pend_time;
              rot_end   <= '0;
              count     <= '0;
              err_ovf   <= '0;
              err_def   <= '0;
              err_unx   <= '0;
              fall_vld  <= '0;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/rotating_beacon_edge_capture_unit.sv @@
// ----------------------------------------------------------------------------
// rotating_beacon_edge_capture_unit
// records beacon fall and rise times per rotation and emits the record
//
// input channel: one beat per event (tick or laser edge) with its level and
// timestamp, on in_valid / in_stall. a two-entry queue takes beats while the
// capture engine is busy, so in_stall rises only when that queue is full.
// output channel: one beat per captured beacon on a closing tick, or a single
// empty beat, on out_valid / out_stall, last set on the final beat.
// edges and deferring ticks give no output. a closing tick gives N results (at
// least one); its first result passes the queue slot, the emit state and the
// output register, and the rest follow one per cycle while out_stall is low,
// limited by the single output register.
// while out_stall is high the output beat holds and an emitting engine waits;
// the queue keeps accepting until it fills.
// reset clears mode, fall-valid flags, counters and both channels; no clearing pass.
// ----------------------------------------------------------------------------
module rotating_beacon_edge_capture_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            func,
  input  logic                            laser_level,
  input  logic [rbec_pkg::TIME_BITS-1:0]  timestamp,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rbec_pkg::TIME_BITS-1:0]  start_time,
  output logic [rbec_pkg::TIME_BITS-1:0]  end_time,
  output logic [rbec_pkg::CNT_BITS-1:0]   beacon_count,
  output logic [rbec_pkg::IDX_BITS-1:0]   beacon_index,
  output logic [rbec_pkg::TIME_BITS-1:0]  fall_time,
  output logic [rbec_pkg::TIME_BITS-1:0]  rise_time,
  output logic [rbec_pkg::ERR_BITS-1:0]   overflow_count,
  output logic [rbec_pkg::ERR_BITS-1:0]   deferred_count,
  output logic [rbec_pkg::ERR_BITS-1:0]   unexpected_count,
  output logic                            last
);

  logic              q_valid;
  logic              q_pop;
  rbec_pkg::entry_t  q_entry;
  rbec_pkg::result_t result;

  rbec_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .laser_level (laser_level),
    .timestamp   (timestamp),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .q_pop       (q_pop)
  );

  rbec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign start_time       = result.start_time;
  assign end_time         = result.end_time;
  assign beacon_count     = result.beacon_count;
  assign beacon_index     = result.beacon_index;
  assign fall_time        = result.fall_time;
  assign rise_time        = result.rise_time;
  assign overflow_count   = result.overflow_count;
  assign deferred_count   = result.deferred_count;
  assign unexpected_count = result.unexpected_count;
  assign last             = result.last;

endmodule
